@@ sv/rdac_pkg.sv @@
// ----------------------------------------------------------------------------
// rdac_pkg
// Shared types, port codes and command decode tables for the RAMDAC
// hidden register port.
// ----------------------------------------------------------------------------
package rdac_pkg;

  localparam int PLL_ENTRIES = 256;
  localparam int PLL_AW      = (PLL_ENTRIES > 1) ? $clog2(PLL_ENTRIES) : 1;

  localparam logic [15:0] PORT_MASK = 16'h03C6;
  localparam logic [15:0] PORT_RIDX = 16'h03C7;
  localparam logic [15:0] PORT_WIDX = 16'h03C8;
  localparam logic [15:0] PORT_DATA = 16'h03C9;

  localparam logic [7:0] ID_BYTE    = 8'h70;
  localparam logic [7:0] LEAVE_CODE = 8'hFF;

  localparam logic [2:0] STREAK_ID  = 3'd4;
  localparam logic [2:0] STREAK_CMD = 3'd5;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       forward_to_vga;
    logic [2:0] color_depth;
    logic       depth_updated;
    logic [2:0] clock_divider_x2;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic [PLL_AW-1:0] addr;
    logic [15:0]       data;
  } pll_wr_t;

  function automatic logic [2:0] depth_code(input logic [3:0] nib);
    logic [2:0] d;
    case (nib)
      4'h0: d = 3'd0;
      4'h1: d = 3'd0;
      4'h2: d = 3'd1;
      4'h3: d = 3'd1;
      4'h4: d = 3'd3;
      4'h5: d = 3'd2;
      4'h6: d = 3'd2;
      4'h7: d = 3'd4;
      4'h8: d = 3'd1;
      4'h9: d = 3'd3;
      4'hA: d = 3'd1;
      4'hB: d = 3'd0;
      4'hC: d = 3'd2;
      4'hD: d = 3'd0;
      4'hE: d = 3'd3;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] divider_code(input logic [3:0] nib);
    logic [2:0] d;
    case (nib)
      4'h0: d = 3'd2;
      4'h1: d = 3'd1;
      4'h2: d = 3'd4;
      4'h3: d = 3'd2;
      4'h4: d = 3'd6;
      4'h5: d = 3'd2;
      4'h6: d = 3'd4;
      4'h7: d = 3'd4;
      4'h8: d = 3'd4;
      4'h9: d = 3'd3;
      4'hA: d = 3'd4;
      4'hB: d = 3'd2;
      4'hC: d = 3'd4;
      4'hD: d = 3'd2;
      4'hE: d = 3'd6;
      default: d = 3'd2;
    endcase
    return d;
  endfunction

endpackage

@@ sv/rdac_pll_store.sv @@
// ----------------------------------------------------------------------------
// rdac_pll_store
// PLL register memory: one write port, one registered read port, per-entry
// valid bits so that entries never written read as zero after reset.
// ----------------------------------------------------------------------------
module rdac_pll_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [rdac_pkg::PLL_AW-1:0] rd_addr,
  input  rdac_pkg::pll_wr_t           wr,
  output logic [15:0]                 rd_data
);

  logic [15:0]                      mem [rdac_pkg::PLL_ENTRIES];
  logic [rdac_pkg::PLL_ENTRIES-1:0] vld_r;
  logic [15:0]                      data_r;
  logic                             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? data_r : 16'h0000;

endmodule

@@ sv/ramdac_hidden_register_port.sv @@
// ----------------------------------------------------------------------------
// ramdac_hidden_register_port
// Hidden command and PLL register port of a true-colour RAMDAC on VGA
// ports 3C6 to 3C9; every access yields one result word.
// ----------------------------------------------------------------------------
// Path: the PLL store is read as the input word is accepted, then the read-modify-write
//   and the result register follow once the output register is free.
// Flow: the single-entry capture stage accepts no new word until the held one is processed,
//   so the PLL store read completes before the next pointer update.
// Reset: synchronous rst_n clears the control registers and the PLL valid
//   bits at once; no clearing pass, ready as soon as reset is released.
module ramdac_hidden_register_port (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rdac_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rdac_pkg::out_word_t out_word
);

  logic                s1_v_r, s1_v_nxt;
  rdac_pkg::in_word_t  item_r;
  logic                out_v_r, out_v_nxt;
  rdac_pkg::out_word_t out_word_r, out_word_nxt;

  logic [2:0] streak_r, streak_nxt;
  logic       hidden_r, hidden_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] rptr_r, rptr_nxt;
  logic [7:0] wptr_r, wptr_nxt;
  logic       hbn_r, hbn_nxt;

  logic              in_fire, fire;
  logic [7:0]        rd_ptr;
  logic [15:0]       old_val;
  logic [7:0]        acc_ptr;
  logic              in_range;
  logic [2:0]        streak_inc;
  rdac_pkg::pll_wr_t wr;

  assign in_ready = !s1_v_r;
  assign in_fire  = in_valid && in_ready;
  assign fire     = s1_v_r && (!out_v_r || out_ready);
  assign rd_ptr   = (in_word.op == rdac_pkg::OP_WRITE) ? wptr_r : rptr_r;

  rdac_pll_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_ptr[rdac_pkg::PLL_AW-1:0]),
    .wr      (wr),
    .rd_data (old_val)
  );

  assign acc_ptr    = (item_r.op == rdac_pkg::OP_WRITE) ? wptr_r : rptr_r;
  assign in_range   = {1'b0, acc_ptr} < 9'(rdac_pkg::PLL_ENTRIES);
  assign streak_inc = (streak_r < rdac_pkg::STREAK_CMD) ? streak_r + 3'd1 : streak_r;

  always_comb begin
    streak_nxt   = streak_r;
    hidden_nxt   = hidden_r;
    cmd_nxt      = cmd_r;
    rptr_nxt     = rptr_r;
    wptr_nxt     = wptr_r;
    hbn_nxt      = hbn_r;
    wr.en        = 1'b0;
    wr.addr      = acc_ptr[rdac_pkg::PLL_AW-1:0];
    wr.data      = old_val;
    out_word_nxt = '0;
    out_word_nxt.forward_to_vga = 1'b1;
    if (item_r.op == rdac_pkg::OP_WRITE) begin
      case (item_r.addr)
        rdac_pkg::PORT_MASK: begin
          if (item_r.write_data == rdac_pkg::LEAVE_CODE) begin
            hidden_nxt = 1'b0;
            streak_nxt = '0;
          end else if (streak_r == rdac_pkg::STREAK_ID) begin
            cmd_nxt                    = item_r.write_data;
            out_word_nxt.depth_updated = 1'b1;
          end
        end
        rdac_pkg::PORT_RIDX: begin
          streak_nxt = '0;
          if (hidden_r) rptr_nxt = item_r.write_data;
        end
        rdac_pkg::PORT_WIDX: begin
          streak_nxt = '0;
          if (hidden_r) wptr_nxt = item_r.write_data;
        end
        rdac_pkg::PORT_DATA: begin
          streak_nxt = '0;
          if (hidden_r) begin
            wr.en   = fire && in_range;
            wr.data = hbn_r ? {item_r.write_data, old_val[7:0]}
                            : {old_val[15:8], item_r.write_data};
            hbn_nxt = !hbn_r;
            if (hbn_r) wptr_nxt = wptr_r + 8'd1;
          end
        end
        default: ;
      endcase
    end else begin
      case (item_r.addr)
        rdac_pkg::PORT_MASK: begin
          hbn_nxt    = 1'b0;
          streak_nxt = streak_inc;
          if (streak_inc == rdac_pkg::STREAK_ID) begin
            out_word_nxt.read_data      = rdac_pkg::ID_BYTE;
            out_word_nxt.forward_to_vga = 1'b0;
            hidden_nxt                  = 1'b1;
          end else if (streak_inc == rdac_pkg::STREAK_CMD) begin
            out_word_nxt.read_data      = cmd_r;
            out_word_nxt.forward_to_vga = 1'b0;
            streak_nxt                  = '0;
          end
        end
        rdac_pkg::PORT_RIDX: begin
          streak_nxt = '0;
          if (hidden_r) begin
            out_word_nxt.read_data      = rptr_r;
            out_word_nxt.forward_to_vga = 1'b0;
          end
        end
        rdac_pkg::PORT_WIDX: begin
          streak_nxt = '0;
          if (hidden_r) begin
            out_word_nxt.read_data      = wptr_r;
            out_word_nxt.forward_to_vga = 1'b0;
          end
        end
        rdac_pkg::PORT_DATA: begin
          streak_nxt = '0;
          if (hidden_r) begin
            if (in_range) begin
              out_word_nxt.read_data = hbn_r ? old_val[15:8] : old_val[7:0];
            end
            out_word_nxt.forward_to_vga = 1'b0;
            hbn_nxt = !hbn_r;
            if (hbn_r) rptr_nxt = rptr_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
    out_word_nxt.color_depth      = rdac_pkg::depth_code(cmd_nxt[7:4]);
    out_word_nxt.clock_divider_x2 = rdac_pkg::divider_code(cmd_nxt[7:4]);
  end

  always_comb begin
    s1_v_nxt  = s1_v_r;
    out_v_nxt = out_v_r;
    if (out_ready) out_v_nxt = 1'b0;
    if (fire) begin
      s1_v_nxt  = 1'b0;
      out_v_nxt = 1'b1;
    end
    if (in_fire) s1_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      streak_r <= '0;
      hidden_r <= 1'b0;
      cmd_r    <= '0;
      rptr_r   <= '0;
      wptr_r   <= '0;
      hbn_r    <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (fire) begin
        streak_r <= streak_nxt;
        hidden_r <= hidden_nxt;
        cmd_r    <= cmd_nxt;
        rptr_r   <= rptr_nxt;
        wptr_r   <= wptr_nxt;
        hbn_r    <= hbn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_word;
    if (fire) out_word_r <= out_word_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_streak_max: assert property (@(posedge clk) disable iff (!rst_n)
    streak_r <= rdac_pkg::STREAK_ID)
    else $error("read streak beyond four");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r && !s1_v_r)
    else $error("processed word not presented");

  a_upd_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_word_r.depth_updated |-> out_word_r.forward_to_vga)
    else $error("command update not forwarded");

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !hidden_r |=> $stable(rptr_r) && $stable(wptr_r))
    else $error("pointer moved outside hidden mode");
`endif

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the RAMDAC hidden register port on VGA ports 3C6 to 3C9: mask-read
// streaks, ID and command reads, command writes and their decode, and the
// auto-incrementing PLL index and data ports. A shadow of the port state
// works out every reply word and compares it with the block's output, while
// both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
class ramdac_shadow;
  bit [2:0]  streak;
  bit        hidden;
  bit [7:0]  command;
  bit [7:0]  rd_ptr;
  bit [7:0]  wr_ptr;
  bit        high_next;
  bit [15:0] pll_regs [rdac_pkg::PLL_ENTRIES];
  bit [2:0]  depth_of [16];
  bit [2:0]  div_of [16];
  rdac_pkg::out_word_t pending [$];
  int        errors;
  int        replies;
  int        cmd_writes;
  int        id_reads;
  int        pll_reads;

  function new();
    depth_of = '{0, 0, 1, 1, 3, 2, 2, 4, 1, 3, 1, 0, 2, 0, 3, 0};
    div_of   = '{2, 1, 4, 2, 6, 2, 4, 4, 4, 3, 4, 2, 4, 2, 6, 2};
  endfunction

  function void note_access(rdac_pkg::in_word_t w);
    rdac_pkg::out_word_t r;
    logic [7:0]          v;
    r = '0;
    r.forward_to_vga = 1'b1;
    v = w.write_data;
    if (w.op == rdac_pkg::OP_WRITE) begin
      case (w.addr)
        rdac_pkg::PORT_MASK: begin
          if (v == rdac_pkg::LEAVE_CODE) begin
            hidden = 1'b0;
            streak = '0;
          end else if (streak == rdac_pkg::STREAK_ID) begin
            command = v;
            r.depth_updated = 1'b1;
            cmd_writes++;
          end
        end
        rdac_pkg::PORT_RIDX: begin
          streak = '0;
          if (hidden) rd_ptr = v;
        end
        rdac_pkg::PORT_WIDX: begin
          streak = '0;
          if (hidden) wr_ptr = v;
        end
        rdac_pkg::PORT_DATA: begin
          streak = '0;
          if (hidden) begin
            if (wr_ptr < rdac_pkg::PLL_ENTRIES) begin
              if (high_next) pll_regs[wr_ptr][15:8] = v;
              else pll_regs[wr_ptr][7:0] = v;
            end
            high_next = !high_next;
            if (!high_next) wr_ptr++;
          end
        end
        default: ;
      endcase
    end else begin
      case (w.addr)
        rdac_pkg::PORT_MASK: begin
          high_next = 1'b0;
          if (streak < rdac_pkg::STREAK_CMD) streak++;
          if (streak == rdac_pkg::STREAK_ID) begin
            r.read_data = rdac_pkg::ID_BYTE;
            r.forward_to_vga = 1'b0;
            hidden = 1'b1;
            id_reads++;
          end else if (streak == rdac_pkg::STREAK_CMD) begin
            r.read_data = command;
            r.forward_to_vga = 1'b0;
            streak = '0;
          end
        end
        rdac_pkg::PORT_RIDX: begin
          streak = '0;
          if (hidden) begin
            r.read_data = rd_ptr;
            r.forward_to_vga = 1'b0;
          end
        end
        rdac_pkg::PORT_WIDX: begin
          streak = '0;
          if (hidden) begin
            r.read_data = wr_ptr;
            r.forward_to_vga = 1'b0;
          end
        end
        rdac_pkg::PORT_DATA: begin
          streak = '0;
          if (hidden) begin
            if (rd_ptr < rdac_pkg::PLL_ENTRIES)
              r.read_data = high_next ? pll_regs[rd_ptr][15:8] : pll_regs[rd_ptr][7:0];
            r.forward_to_vga = 1'b0;
            high_next = !high_next;
            if (!high_next) rd_ptr++;
            pll_reads++;
          end
        end
        default: ;
      endcase
    end
    r.color_depth      = depth_of[command[7:4]];
    r.clock_divider_x2 = div_of[command[7:4]];
    pending.push_back(r);
  endfunction

  task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= 40)
      $display("tb_top: mismatch in %s at reply %0d: got 0x%0h, want 0x%0h",
               what, replies, got, want);
  endtask

  task check_reply(rdac_pkg::out_word_t got);
    rdac_pkg::out_word_t want;
    if (pending.size() == 0) begin
      report_mismatch("unexpected word", got, 16'h0);
    end else begin
      want = pending.pop_front();
      replies++;
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", 16'(got.read_data), 16'(want.read_data));
      if (got.forward_to_vga !== want.forward_to_vga)
        report_mismatch("forward_to_vga", 16'(got.forward_to_vga),
                        16'(want.forward_to_vga));
      if (got.color_depth !== want.color_depth)
        report_mismatch("color_depth", 16'(got.color_depth), 16'(want.color_depth));
      if (got.depth_updated !== want.depth_updated)
        report_mismatch("depth_updated", 16'(got.depth_updated),
                        16'(want.depth_updated));
      if (got.clock_divider_x2 !== want.clock_divider_x2)
        report_mismatch("clock_divider_x2", 16'(got.clock_divider_x2),
                        16'(want.clock_divider_x2));
    end
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 900;
  localparam int CALM_WORDS   = 100;
  localparam int SQUEEZE_AT   = 300;
  localparam int HOLD_OFF     = 200;
  localparam int QUIET_LIMIT  = 2000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  rdac_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  rdac_pkg::out_word_t out_word;

  bit                 calm;
  bit                 squeeze_req;
  rdac_pkg::in_word_t plan [$];
  ramdac_shadow       shadow;

  ramdac_hidden_register_port u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_access(logic op, logic [15:0] addr, logic [7:0] data);
    rdac_pkg::in_word_t w;
    w.op         = op;
    w.addr       = addr;
    w.write_data = data;
    plan.push_back(w);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) shadow.note_access(in_word);
      if (out_valid && out_ready) shadow.check_reply(out_word);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: no handshake for %0d cycles", QUIET_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    int         idx;
    int         counted;
    int         mark;
    int         n;
    bit         noise;
    logic [7:0] p;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    shadow   = new();

    // early mask reads, ID read, command writes, command read
    repeat (4) add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_MASK, 8'h00);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, 8'h70);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, 8'hE5);
    add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_MASK, 8'hFF);
    // pointer wrap on the top PLL entry
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_WIDX, 8'hFF);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_DATA, 8'h00);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_DATA, 8'hFF);
    add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_WIDX, 8'h00);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_RIDX, 8'hFF);
    add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_DATA, 8'h00);
    add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_DATA, 8'h00);
    add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_RIDX, 8'h00);
    // short-streak mask write, leave hidden mode, other ports
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, 8'h12);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, rdac_pkg::LEAVE_CODE);
    add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_DATA, 8'h00);
    add_access(rdac_pkg::OP_READ, 16'h0000, 8'h00);
    add_access(rdac_pkg::OP_WRITE, 16'hFFFF, 8'hAA);
    // unused nibble, then command zero
    repeat (4) add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_MASK, 8'h00);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, 8'hF0);
    add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, 8'h00);

    counted = 0;
    while (counted < RANDOM_WORDS) begin
      mark  = plan.size();
      noise = 1'b0;
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat (4)
            add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_MASK, 8'($urandom_range(0, 255)));
          n = $urandom_range(0, 3);
          repeat (n)
            add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK,
                       ($urandom_range(0, 7) == 0) ? rdac_pkg::LEAVE_CODE
                                                   : 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1)
            add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_MASK, 8'($urandom_range(0, 255)));
        end
        2, 3, 4, 5: begin
          p = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 7));
          add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_WIDX, p);
          repeat ($urandom_range(1, 6))
            add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_DATA, 8'($urandom_range(0, 255)));
          add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_RIDX, p);
          if ($urandom_range(0, 3) == 0)
            add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_WIDX, 8'($urandom_range(0, 255)));
          repeat ($urandom_range(1, 6))
            add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_DATA, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0)
            add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_RIDX, 8'($urandom_range(0, 255)));
        end
        6: begin
          repeat ($urandom_range(1, 3))
            add_access(rdac_pkg::OP_READ, rdac_pkg::PORT_MASK, 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1)
            add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, 8'($urandom_range(0, 254)));
          else
            add_access(1'($urandom_range(0, 1)),
                       16'(rdac_pkg::PORT_RIDX + $urandom_range(0, 2)),
                       8'($urandom_range(0, 255)));
        end
        7: add_access(rdac_pkg::OP_WRITE, rdac_pkg::PORT_MASK, rdac_pkg::LEAVE_CODE);
        8: begin
          noise = 1'b1;
          add_access(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)));
        end
        default:
          add_access(1'($urandom_range(0, 1)),
                     16'(rdac_pkg::PORT_MASK + $urandom_range(0, 3)),
                     8'($urandom_range(0, 255)));
      endcase
      if (!noise) counted += plan.size() - mark;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (idx = 0; idx < plan.size(); idx++) begin
      if (idx == SQUEEZE_AT) squeeze_req = 1'b1;
      calm = (idx >= plan.size() - CALM_WORDS);
      if (!calm && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_word  <= plan[idx];
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb_top: %0d words checked: %0d ID reads, %0d command writes, %0d PLL data reads",
             shadow.replies, shadow.id_reads, shadow.cmd_writes, shadow.pll_reads);
    $display("tb_top: %0d mismatches", shadow.errors);
    if (shadow.errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
